FILE: hw/rtl/kpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpu_pkg
// Shared register indexes, reset values and lane routing helpers for the
// kinetic pair update block.
// ----------------------------------------------------------------------------
package kpu_pkg;

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COEF_A     = 2'd0,
      CSR_COEF_B     = 2'd1,
      CSR_IMAG_MODE  = 2'd2
   } csr_index_type;

   // Reset value of coef_a, truncated to the data width at use.
   localparam logic [63:0] COEF_A_RESET = 64'd1073741824;

   localparam int NUM_LANES = 4;

   typedef logic [1:0] lane_type;

   // Lanes are ordered first_re, first_im, peer_re, peer_im.
   // The second operand of a lane comes from the lane given here.
   function automatic lane_type peer_lane(input lane_type lane, input logic imag_mode);
      lane_type sel;
      sel = imag_mode ? lane_type'(2'd2) : lane_type'(2'd3);
      return lane ^ sel;
   endfunction

   // In real-time mode the real parts take the off-diagonal term negated.
   function automatic logic lane_subtracts(input lane_type lane, input logic imag_mode);
      return !imag_mode && !lane[0];
   endfunction

endpackage

FILE: hw/rtl/kpu_prod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpu_prod
// Full-precision signed products a*x and b*y of one output lane.
// ----------------------------------------------------------------------------
module kpu_prod #(
   parameter int DATA_WIDTH = 32
) (
   input  logic signed [DATA_WIDTH-1:0]   coef_a,
   input  logic signed [DATA_WIDTH-1:0]   coef_b,
   input  logic signed [DATA_WIDTH-1:0]   opnd_x,
   input  logic signed [DATA_WIDTH-1:0]   opnd_y,
   output logic signed [2*DATA_WIDTH-1:0] prod_a,
   output logic signed [2*DATA_WIDTH-1:0] prod_b
);

   localparam int PW = 2 * DATA_WIDTH;

   assign prod_a = PW'(coef_a) * PW'(opnd_x);
   assign prod_b = PW'(coef_b) * PW'(opnd_y);

endmodule

FILE: hw/rtl/kpu_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpu_mix
// Rounds two products to the fixed-point grid, adds or subtracts them exactly
// and saturates the sum to the data width.
// ----------------------------------------------------------------------------
module kpu_mix #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 30
) (
   input  logic signed [2*DATA_WIDTH-1:0] prod_a,
   input  logic signed [2*DATA_WIDTH-1:0] prod_b,
   input  logic                           sub,
   output logic signed [DATA_WIDTH-1:0]   result,
   output logic                           sat
);

   localparam int PW = 2 * DATA_WIDTH;
   localparam int XW = (PW > FRAC_BITS) ? PW : FRAC_BITS + 1;
   localparam int RW = XW - FRAC_BITS;
   localparam int SW = (RW + 1 > DATA_WIDTH) ? RW + 1 : DATA_WIDTH + 1;
   localparam logic signed [XW-1:0] HALF = XW'(1'b1) << (FRAC_BITS - 1);
   localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic signed [XW-1:0]      bias_a;
   logic signed [XW-1:0]      bias_b;
   logic signed [XW-1:0]      shf_a;
   logic signed [XW-1:0]      shf_b;
   logic signed [RW-1:0]      rnd_a;
   logic signed [RW-1:0]      rnd_b;
   logic signed [SW-1:0]      sum;
   logic [SW-DATA_WIDTH:0]    top_bits;

   // Ties round toward plus infinity.
   assign bias_a = XW'(prod_a) + HALF;
   assign bias_b = XW'(prod_b) + HALF;
   assign shf_a  = bias_a >>> FRAC_BITS;
   assign shf_b  = bias_b >>> FRAC_BITS;
   assign rnd_a  = $signed(shf_a[RW-1:0]);
   assign rnd_b  = $signed(shf_b[RW-1:0]);

   assign sum = sub ? (SW'(rnd_a) - SW'(rnd_b)) : (SW'(rnd_a) + SW'(rnd_b));

   assign top_bits = sum[SW-1:DATA_WIDTH-1];
   assign sat      = !((&top_bits) || !(|top_bits));

   always_comb begin
      if (!sat) begin
         result = sum[DATA_WIDTH-1:0];
      end else if (sum[SW-1]) begin
         result = MIN_VAL;
      end else begin
         result = MAX_VAL;
      end
   end

endmodule

FILE: hw/rtl/kinetic_pair_update.sv
`timescale 1ns / 1ps
// An accepted request beat passes through the input register, the product
// register and the result register. Throughput: one pair per cycle while
// rsp_ready holds; the four lanes multiply in parallel.
// Reset clears all valid flags and loads coef_a with 1.0, coef_b with 0 and
// real-time mode.
// ----------------------------------------------------------------------------
// kinetic_pair_update
// Split-step kinetic pair mix of two complex samples with saturating
// fixed-point arithmetic, as a three-register elastic pipeline.
// ----------------------------------------------------------------------------
module kinetic_pair_update #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 30
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [DATA_WIDTH-1:0]       req_first_re,
   input  logic signed [DATA_WIDTH-1:0]       req_first_im,
   input  logic signed [DATA_WIDTH-1:0]       req_peer_re,
   input  logic signed [DATA_WIDTH-1:0]       req_peer_im,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [DATA_WIDTH-1:0]       rsp_new_first_re,
   output logic signed [DATA_WIDTH-1:0]       rsp_new_first_im,
   output logic signed [DATA_WIDTH-1:0]       rsp_new_peer_re,
   output logic signed [DATA_WIDTH-1:0]       rsp_new_peer_im,
   output logic                               rsp_saturated,
   input  logic                               csr_wen,
   input  logic [kpu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [DATA_WIDTH-1:0]              csr_wdata
);

   import kpu_pkg::*;

   localparam int PW = 2 * DATA_WIDTH;

   logic signed [DATA_WIDTH-1:0] coef_a_ff;
   logic signed [DATA_WIDTH-1:0] coef_b_ff;
   logic                         imag_mode_ff;

   logic                         smp_valid_ff;
   logic signed [DATA_WIDTH-1:0] smp_ff [NUM_LANES];
   logic signed [DATA_WIDTH-1:0] smp_in [NUM_LANES];

   logic                         prod_valid_ff;
   logic signed [PW-1:0]         prod_a_ff [NUM_LANES];
   logic signed [PW-1:0]         prod_b_ff [NUM_LANES];
   logic signed [PW-1:0]         prod_a_in [NUM_LANES];
   logic signed [PW-1:0]         prod_b_in [NUM_LANES];

   logic                         out_valid_ff;
   logic signed [DATA_WIDTH-1:0] out_ff [NUM_LANES];
   logic signed [DATA_WIDTH-1:0] out_in [NUM_LANES];
   logic                         out_sat_ff;
   logic [NUM_LANES-1:0]         lane_sat;

   logic                         out_take;
   logic                         prod_free;
   logic                         smp_free;

   assign out_take  = !out_valid_ff || rsp_ready;
   assign prod_free = !prod_valid_ff || out_take;
   assign smp_free  = !smp_valid_ff || prod_free;

   assign req_ready = smp_free;

   assign smp_in[0] = req_first_re;
   assign smp_in[1] = req_first_im;
   assign smp_in[2] = req_peer_re;
   assign smp_in[3] = req_peer_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff    <= DATA_WIDTH'(COEF_A_RESET);
         coef_b_ff    <= '0;
         imag_mode_ff <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_COEF_A:    coef_a_ff    <= csr_wdata;
            CSR_COEF_B:    coef_b_ff    <= csr_wdata;
            CSR_IMAG_MODE: imag_mode_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      localparam lane_type LANE = lane_type'(l);
      localparam int PEER_REAL = int'(peer_lane(LANE, 1'b0));
      localparam int PEER_IMAG = int'(peer_lane(LANE, 1'b1));

      logic signed [DATA_WIDTH-1:0] opnd_y;

      assign opnd_y = imag_mode_ff ? smp_ff[PEER_IMAG] : smp_ff[PEER_REAL];

      kpu_prod #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_prod (
         .coef_a (coef_a_ff),
         .coef_b (coef_b_ff),
         .opnd_x (smp_ff[l]),
         .opnd_y (opnd_y),
         .prod_a (prod_a_in[l]),
         .prod_b (prod_b_in[l])
      );

      kpu_mix #(
         .DATA_WIDTH (DATA_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_mix (
         .prod_a (prod_a_ff[l]),
         .prod_b (prod_b_ff[l]),
         .sub    (lane_subtracts(LANE, imag_mode_ff)),
         .result (out_in[l]),
         .sat    (lane_sat[l])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (smp_free) begin
            smp_valid_ff <= req_valid;
         end
         if (prod_free) begin
            prod_valid_ff <= smp_valid_ff;
         end
         if (out_take) begin
            out_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (smp_free && req_valid) begin
         smp_ff <= smp_in;
      end
      if (prod_free && smp_valid_ff) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
      if (out_take && prod_valid_ff) begin
         out_ff     <= out_in;
         out_sat_ff <= |lane_sat;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_new_first_re = out_ff[0];
   assign rsp_new_first_im = out_ff[1];
   assign rsp_new_peer_re  = out_ff[2];
   assign rsp_new_peer_im  = out_ff[3];
   assign rsp_saturated    = out_sat_ff;

endmodule

FILE: hw/rtl/kpu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpu_checker
// Port-level checks of the kinetic pair update block: beat accounting,
// pipeline depth and response hold.
// ----------------------------------------------------------------------------
module kpu_checker #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [DATA_WIDTH-1:0]       rsp_new_first_re,
   input  logic signed [DATA_WIDTH-1:0]       rsp_new_first_im,
   input  logic signed [DATA_WIDTH-1:0]       rsp_new_peer_re,
   input  logic signed [DATA_WIDTH-1:0]       rsp_new_peer_im,
   input  logic                               rsp_saturated
);

   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 3'd1;
      end else if (rsp_beat && !req_beat) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A response beat always belongs to an earlier request beat.
   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 3'd0))
      else $error("response beat without a pending request");

   // The pipeline holds at most three pairs.
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd3)
      else $error("more pairs in flight than pipeline stages");

   // With the result register empty, every stage can move.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side stalled while result register is empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_first_re)
         && $stable(rsp_new_first_im) && $stable(rsp_new_peer_re)
         && $stable(rsp_new_peer_im) && $stable(rsp_saturated))
      else $error("stalled response beat changed");

endmodule

bind kinetic_pair_update kpu_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_kpu_checker (.*);

FILE: tb/tb_kinetic_pair_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kinetic_pair_update
// Self-checking bench for the kinetic pair update block. A short table of
// directed pairs and register writes runs first. Random pairs under a series
// of coefficient and mode settings follow. Every response beat is compared
// field by field with a table entry or a bit-exact fixed-point model of the pair mix.
// ----------------------------------------------------------------------------
module tb_kinetic_pair_update;
   import kpu_pkg::*;

   localparam int DW           = 32;
   localparam int FRAC         = 30;
   localparam int LATENCY      = 3;
   localparam int RAND_PHASES  = 12;
   localparam int PHASE_PAIRS  = 100;
   localparam longint TIMEOUT_NS = 2_000_000;

   localparam logic signed [DW-1:0] S_MIN  = 32'sh8000_0000;
   localparam logic signed [DW-1:0] S_MAX  = 32'sh7fff_ffff;
   localparam logic signed [DW-1:0] S_ONE  = 32'sh4000_0000;
   localparam logic signed [DW-1:0] S_HALF = 32'sh2000_0000;

   localparam logic signed [65:0] HALF_LSB = 66'sd1 <<< (FRAC - 1);
   localparam logic signed [65:0] SUM_MAX  = 66'sd2147483647;
   localparam logic signed [65:0] SUM_MIN  = -66'sd2147483648;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct packed {
      logic signed [DW-1:0] first_re;
      logic signed [DW-1:0] first_im;
      logic signed [DW-1:0] peer_re;
      logic signed [DW-1:0] peer_im;
   } pair_req_t;

   typedef struct packed {
      logic signed [DW-1:0] new_first_re;
      logic signed [DW-1:0] new_first_im;
      logic signed [DW-1:0] new_peer_re;
      logic signed [DW-1:0] new_peer_im;
      logic                 saturated;
   } pair_rsp_t;

   typedef struct {
      bit                     is_write;
      logic [CSR_INDEX_W-1:0] wr_index;
      logic [DW-1:0]          wr_data;
      pair_req_t              pair;
      bit                     typed;
      pair_rsp_t              want;
   } dir_row_t;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic signed [DW-1:0]   req_first_re;
   logic signed [DW-1:0]   req_first_im;
   logic signed [DW-1:0]   req_peer_re;
   logic signed [DW-1:0]   req_peer_im;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic signed [DW-1:0]   rsp_new_first_re;
   logic signed [DW-1:0]   rsp_new_first_im;
   logic signed [DW-1:0]   rsp_new_peer_re;
   logic signed [DW-1:0]   rsp_new_peer_im;
   logic                   rsp_saturated;
   logic                   csr_wen;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DW-1:0]          csr_wdata;

   logic signed [DW-1:0] mix_a;
   logic signed [DW-1:0] mix_b;
   logic                 mix_imag;

   pair_rsp_t pending_pairs[$];
   dir_row_t  dir_rows[$];
   bit        steady;
   int        fail_count;
   int        pair_count;
   int        rsp_count;
   int        sat_count;
   int        setting_count;

   kinetic_pair_update #(
      .DATA_WIDTH (DW),
      .FRAC_BITS  (FRAC)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_first_re     (req_first_re),
      .req_first_im     (req_first_im),
      .req_peer_re      (req_peer_re),
      .req_peer_im      (req_peer_im),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_new_first_re (rsp_new_first_re),
      .rsp_new_first_im (rsp_new_first_im),
      .rsp_new_peer_re  (rsp_new_peer_re),
      .rsp_new_peer_im  (rsp_new_peer_im),
      .rsp_saturated    (rsp_saturated),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("kinetic_pair_update test failed");
      $finish;
   end

   function automatic logic signed [65:0] round_product(input logic signed [DW-1:0] c,
                                                        input logic signed [DW-1:0] x);
      logic signed [65:0] p;
      p = c * x;
      p = p + HALF_LSB;
      return p >>> FRAC;
   endfunction

   function automatic logic signed [DW-1:0] mix_lane(input logic signed [DW-1:0] x,
                                                     input logic signed [DW-1:0] y,
                                                     input bit sub, inout logic sat);
      logic signed [65:0] off;
      logic signed [65:0] s;
      off = round_product(mix_b, y);
      s = round_product(mix_a, x) + (sub ? -off : off);
      if (s > SUM_MAX) begin
         sat = 1'b1;
         return S_MAX;
      end
      if (s < SUM_MIN) begin
         sat = 1'b1;
         return S_MIN;
      end
      return s[DW-1:0];
   endfunction

   function automatic pair_rsp_t kinetic_mix(input pair_req_t p);
      pair_rsp_t r;
      logic      sat;
      sat = 1'b0;
      if (mix_imag) begin
         r.new_first_re = mix_lane(p.first_re, p.peer_re, 1'b0, sat);
         r.new_first_im = mix_lane(p.first_im, p.peer_im, 1'b0, sat);
         r.new_peer_re  = mix_lane(p.peer_re, p.first_re, 1'b0, sat);
         r.new_peer_im  = mix_lane(p.peer_im, p.first_im, 1'b0, sat);
      end else begin
         r.new_first_re = mix_lane(p.first_re, p.peer_im, 1'b1, sat);
         r.new_first_im = mix_lane(p.first_im, p.peer_re, 1'b0, sat);
         r.new_peer_re  = mix_lane(p.peer_re, p.first_im, 1'b1, sat);
         r.new_peer_im  = mix_lane(p.peer_im, p.first_re, 1'b0, sat);
      end
      r.saturated = sat;
      return r;
   endfunction

   function automatic dir_row_t row_write(input logic [CSR_INDEX_W-1:0] idx,
                                          input logic [DW-1:0] data);
      dir_row_t r;
      r = '{default: '0};
      r.is_write = 1'b1;
      r.wr_index = idx;
      r.wr_data  = data;
      return r;
   endfunction

   function automatic dir_row_t row_pair(input pair_req_t p, input bit typed,
                                         input pair_rsp_t want);
      dir_row_t r;
      r = '{default: '0};
      r.pair  = p;
      r.typed = typed;
      r.want  = want;
      return r;
   endfunction

   function automatic logic signed [DW-1:0] draw_sample();
      logic signed [DW-1:0] v;
      case ($urandom_range(0, 9))
         0: v = S_MIN;
         1: v = S_MAX;
         2: v = '0;
         3: v = $urandom_range(0, 4096);
         4: v = DW'(-$signed({1'b0, S_ONE}) + $urandom_range(0, 32'h7fff_ffff));
         default: v = $urandom;
      endcase
      if (v != S_MIN && $urandom_range(0, 3) == 0) v = -v;
      return v;
   endfunction

   function automatic logic signed [DW-1:0] draw_coef();
      case ($urandom_range(0, 7))
         0: return S_MIN;
         1: return S_MAX;
         2: return '0;
         3: return S_ONE;
         4: return -S_ONE;
         default: return $urandom;
      endcase
   endfunction

   task automatic cmp_field(input string name, input logic [DW-1:0] want,
                            input logic [DW-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic await_idle();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [DW-1:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_COEF_A:    mix_a = data;
         CSR_COEF_B:    mix_b = data;
         CSR_IMAG_MODE: mix_imag = data[0];
         default:       ;
      endcase
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pair(input pair_req_t p, input bit typed, input pair_rsp_t want);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_first_re <= p.first_re;
      req_first_im <= p.first_im;
      req_peer_re  <= p.peer_re;
      req_peer_im  <= p.peer_im;
      do @(posedge clock); while (!req_ready);
      pending_pairs.push_back(typed ? want : kinetic_mix(p));
      pair_count++;
   endtask

   always @(posedge clock) begin : check_rsp
      pair_rsp_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pairs.size() == 0) begin
            $display("%0t: response beat with nothing expected, actual %h %h %h %h %b",
                     $time, rsp_new_first_re, rsp_new_first_im, rsp_new_peer_re,
                     rsp_new_peer_im, rsp_saturated);
            fail_count++;
         end else begin
            want = pending_pairs.pop_front();
            cmp_field("new_first_re", want.new_first_re, rsp_new_first_re);
            cmp_field("new_first_im", want.new_first_im, rsp_new_first_im);
            cmp_field("new_peer_re", want.new_peer_re, rsp_new_peer_re);
            cmp_field("new_peer_im", want.new_peer_im, rsp_new_peer_im);
            cmp_field("saturated", DW'(want.saturated), DW'(rsp_saturated));
            rsp_count++;
            if (rsp_saturated) sat_count++;
         end
      end
   end

   initial begin : rsp_side
      int stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : req_side
      pair_req_t p;
      logic [DW-1:0] mode_word;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_first_re  = '0;
      req_first_im  = '0;
      req_peer_re   = '0;
      req_peer_im   = '0;
      csr_wen       = 1'b0;
      csr_index     = CSR_COEF_A;
      csr_wdata     = '0;
      mix_a         = S_ONE;
      mix_b         = '0;
      mix_imag      = 1'b0;
      steady        = 1'b0;
      fail_count    = 0;
      pair_count    = 0;
      rsp_count     = 0;
      sat_count     = 0;
      setting_count = 1;

      // With the reset coefficients the mix is the identity.
      p = '{'0, '0, '0, '0};
      dir_rows.push_back(row_pair(p, 1'b1, '{p.first_re, p.first_im, p.peer_re, p.peer_im, 1'b0}));
      p = '{S_MAX, S_MAX, S_MAX, S_MAX};
      dir_rows.push_back(row_pair(p, 1'b1, '{p.first_re, p.first_im, p.peer_re, p.peer_im, 1'b0}));
      p = '{S_MIN, S_MIN, S_MIN, S_MIN};
      dir_rows.push_back(row_pair(p, 1'b1, '{p.first_re, p.first_im, p.peer_re, p.peer_im, 1'b0}));
      p = '{32'sd1, -32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa};
      dir_rows.push_back(row_pair(p, 1'b1, '{p.first_re, p.first_im, p.peer_re, p.peer_im, 1'b0}));
      p = '{S_MAX, S_MIN, -32'sd1, 32'sd1};
      dir_rows.push_back(row_pair(p, 1'b1, '{p.first_re, p.first_im, p.peer_re, p.peer_im, 1'b0}));

      // Both coefficients at the most negative value, real-time mode.
      dir_rows.push_back(row_write(CSR_COEF_A, S_MIN));
      dir_rows.push_back(row_write(CSR_COEF_B, S_MIN));
      dir_rows.push_back(row_pair('{'0, '0, '0, '0}, 1'b1, '{'0, '0, '0, '0, 1'b0}));
      dir_rows.push_back(row_pair('{S_MIN, S_MIN, S_MIN, S_MIN}, 1'b1,
                                  '{'0, S_MAX, '0, S_MAX, 1'b1}));
      dir_rows.push_back(row_pair('{S_MAX, S_MAX, S_MAX, S_MAX}, 1'b0, '0));
      dir_rows.push_back(row_pair('{S_MIN, S_MAX, 32'sd1, -32'sd1}, 1'b0, '0));

      // Both coefficients at the largest value, imaginary-time mode.
      dir_rows.push_back(row_write(CSR_COEF_A, S_MAX));
      dir_rows.push_back(row_write(CSR_COEF_B, S_MAX));
      dir_rows.push_back(row_write(CSR_IMAG_MODE, 32'h8000_0001));
      dir_rows.push_back(row_pair('{S_MAX, S_MAX, S_MAX, S_MAX}, 1'b1,
                                  '{S_MAX, S_MAX, S_MAX, S_MAX, 1'b1}));
      dir_rows.push_back(row_pair('{S_MIN, S_MIN, S_MIN, S_MIN}, 1'b1,
                                  '{S_MIN, S_MIN, S_MIN, S_MIN, 1'b1}));
      dir_rows.push_back(row_pair('{S_MAX, S_MIN, '0, -32'sd1}, 1'b0, '0));

      // One-LSB coefficients expose the round-half-up ties; only bit 0 of the
      // mode word counts.
      dir_rows.push_back(row_write(CSR_COEF_A, 32'sd1));
      dir_rows.push_back(row_write(CSR_COEF_B, 32'sd1));
      dir_rows.push_back(row_write(CSR_IMAG_MODE, 32'hffff_fffe));
      dir_rows.push_back(row_pair('{S_HALF, -S_HALF, 32'sh6000_0000, 32'sha000_0000},
                                  1'b0, '0));
      dir_rows.push_back(row_pair('{S_HALF - 1, -S_HALF - 1, S_HALF + 1, S_MIN}, 1'b0, '0));
      dir_rows.push_back(row_write(CSR_UNUSED_INDEX, 32'hffff_ffff));
      dir_rows.push_back(row_pair('{S_HALF, -S_HALF, S_MAX, S_MIN}, 1'b0, '0));

      dir_rows.push_back(row_write(CSR_COEF_A, -S_ONE));
      dir_rows.push_back(row_write(CSR_COEF_B, S_ONE));
      dir_rows.push_back(row_write(CSR_IMAG_MODE, 32'h0000_0001));
      dir_rows.push_back(row_pair('{32'sh1234_5678, 32'shedcb_a987, S_MIN, S_MAX}, 1'b0, '0));
      dir_rows.push_back(row_pair('{S_MIN, S_MIN, 32'sh7654_3210, -32'sd1}, 1'b0, '0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_write) begin
            await_idle();
            csr_write(dir_rows[i].wr_index, dir_rows[i].wr_data);
            setting_count++;
         end else begin
            send_pair(dir_rows[i].pair, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         await_idle();
         csr_write(CSR_COEF_A, draw_coef());
         csr_write(CSR_COEF_B, draw_coef());
         mode_word = $urandom;
         mode_word[0] = ph[0];
         csr_write(CSR_IMAG_MODE, mode_word);
         if ($urandom_range(0, 3) == 0) csr_write(CSR_UNUSED_INDEX, $urandom);
         setting_count++;
         steady = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_PAIRS; n++) begin
            p = '{draw_sample(), draw_sample(), draw_sample(), draw_sample()};
            send_pair(p, 1'b0, '0);
         end
      end
      steady = 1'b0;
      await_idle();

      $display("Sent %0d pair beats under %0d register settings in both modes.",
               pair_count, setting_count);
      $display("Checked %0d response beats, %0d of them saturated.", rsp_count, sat_count);
      if (fail_count == 0) begin
         $display("kinetic_pair_update test passed");
      end else begin
         $display("kinetic_pair_update test failed");
      end
      $finish;
   end

endmodule
